/* hw/rtl/vcdm_pkg.sv */
// Shared types, codes and constants for the vector-clock mutex node.
package vcdm_pkg;

	localparam int N_PEERS = 8;
	localparam int QCAP    = N_PEERS - 1;
	localparam int CLK_W   = 32;
	localparam int PEER_W  = 3;
	localparam int CNT_W   = 4;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_SEND    = 3'd1;
	localparam logic [2:0] OP_LOCK    = 3'd2;
	localparam logic [2:0] OP_UNLOCK  = 3'd3;
	localparam logic [2:0] OP_REPORT  = 3'd4;
	localparam logic [2:0] OP_RX_MSG  = 3'd5;
	localparam logic [2:0] OP_RX_LOCK = 3'd6;
	localparam logic [2:0] OP_RX_OK   = 3'd7;

	localparam logic [2:0] K_MSG    = 3'd0;
	localparam logic [2:0] K_LOCK   = 3'd1;
	localparam logic [2:0] K_OK     = 3'd2;
	localparam logic [2:0] K_REPORT = 3'd3;
	localparam logic [2:0] K_ENTER  = 3'd4;
	localparam logic [2:0] K_ERROR  = 3'd5;

	localparam logic REG_SELF_INDEX = 1'b0;
	localparam logic REG_PEER_COUNT = 1'b1;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [PEER_W-1:0] peer;
		logic [7:0]        lock_id;
		logic [CLK_W-1:0]  clock_value;
		logic              element_last;
	} item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [PEER_W-1:0] dest_peer;
		logic [7:0]        out_lock;
		logic [CLK_W-1:0]  out_clock;
		logic [2:0]        clock_position;
		logic              last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_COPY, S_BCAST, S_UNLK, S_SEND, S_RXEND, S_ERR, S_ENTER
	} state_t;

	typedef enum logic [1:0] {RD_SELF, RD_POS, RD_ELEM} rd_sel_t;

	typedef enum logic [1:0] {M_ONE, M_BCAST, M_UNLK} mode_t;

	typedef struct packed {
		logic       load_item;
		logic       tick;
		logic       tick2;
		rd_sel_t    rd_sel;
		logic       rx_elem;
		logic       rx_clear;
		logic       alloc;
		logic       copy_row;
		logic       set_cur_hit;
		logic       q_append;
		logic       grant_inc;
		logic       set_inside;
		logic       free_slot;
		logic       elem_clr;
		logic       elem_inc;
		logic       dest_peer;
		logic       dest_zero;
		logic       dest_inc;
		logic       dest_wait;
		logic       qi_clr;
		logic       qi_inc;
		logic       push;
		logic [2:0] kind;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       element_last;
		logic       peer_ok;
		logic       hit;
		logic       full;
		logic       q_full;
		logic       q_done;
		logic       wait_final;
		logic       dest_is_self;
		logic       dest_done;
		logic       dest_final;
		logic       elem_last;
		logic       queue_dec;
		logic       grant_sat;
		logic       grant_enter;
		logic       out_free;
	} sts_t;

endpackage

/* hw/rtl/vcdm_item_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface vcdm_item_if;
	import vcdm_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vcdm_result_if;
	import vcdm_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/vcdm_ctrl.sv */
// Sequencer for the mutex node: decodes items and steps through sends.
module vcdm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vcdm_pkg::sts_t sts,
	output vcdm_pkg::cmd_t cmd
);
	import vcdm_pkg::*;

	state_t     state_q, state_d;
	mode_t      mode_q, mode_d;
	logic [2:0] kind_q, kind_d;
	logic       final_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= M_ONE;
			kind_q  <= K_MSG;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		unique case (mode_q)
			M_ONE:   final_vec = 1'b1;
			M_BCAST: final_vec = sts.dest_final;
			M_UNLK:  final_vec = sts.wait_final;
			default: final_vec = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (sts.opcode)
					OP_TICK:   state_d = S_IDLE;
					OP_SEND:   state_d = sts.peer_ok ? S_SEND : S_ERR;
					OP_LOCK:   state_d = (sts.hit || sts.full) ? S_ERR : S_COPY;
					OP_UNLOCK: state_d = sts.hit ? S_UNLK : S_ERR;
					OP_REPORT: state_d = S_SEND;
					default:   state_d = sts.element_last ? S_RXEND : S_IDLE;
				endcase
			end
			S_COPY: state_d = S_BCAST;
			S_BCAST: begin
				if (sts.dest_done) state_d = S_IDLE;
				else if (!sts.dest_is_self) state_d = S_SEND;
			end
			S_UNLK: state_d = sts.q_done ? S_IDLE : S_SEND;
			S_SEND: begin
				if (sts.out_free && sts.elem_last) begin
					unique case (mode_q)
						M_BCAST: state_d = S_BCAST;
						M_UNLK:  state_d = S_UNLK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RXEND: begin
				if (!sts.peer_ok) state_d = S_ERR;
				else begin
					unique case (sts.opcode)
						OP_RX_LOCK: begin
							if (!sts.queue_dec) state_d = S_SEND;
							else if (sts.q_full) state_d = S_ERR;
							else state_d = S_IDLE;
						end
						OP_RX_OK: begin
							if (!sts.hit) state_d = S_ERR;
							else if (!sts.grant_sat && sts.grant_enter) state_d = S_ENTER;
							else state_d = S_IDLE;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ERR:   if (sts.out_free) state_d = S_IDLE;
			S_ENTER: if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_SELF;
		in_ready = 1'b0;
		mode_d   = mode_q;
		kind_d   = kind_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_DECODE: begin
				unique case (sts.opcode)
					OP_TICK: cmd.tick = 1'b1;
					OP_SEND: begin
						cmd.tick      = 1'b1;
						cmd.dest_peer = 1'b1;
						cmd.elem_clr  = 1'b1;
						kind_d        = K_MSG;
						mode_d        = M_ONE;
					end
					OP_LOCK: begin
						if (!(sts.hit || sts.full)) begin
							cmd.alloc = 1'b1;
							cmd.tick  = 1'b1;
						end
					end
					OP_UNLOCK: begin
						cmd.set_cur_hit = 1'b1;
						cmd.qi_clr      = 1'b1;
					end
					OP_REPORT: begin
						cmd.dest_zero = 1'b1;
						cmd.elem_clr  = 1'b1;
						kind_d        = K_REPORT;
						mode_d        = M_ONE;
					end
					default: begin
						cmd.rd_sel  = RD_POS;
						cmd.rx_elem = 1'b1;
					end
				endcase
			end
			S_COPY: begin
				cmd.copy_row  = 1'b1;
				cmd.dest_zero = 1'b1;
				kind_d        = K_LOCK;
				mode_d        = M_BCAST;
			end
			S_BCAST: begin
				if (!sts.dest_done) begin
					if (sts.dest_is_self) cmd.dest_inc = 1'b1;
					else cmd.elem_clr = 1'b1;
				end
			end
			S_UNLK: begin
				if (sts.q_done) cmd.free_slot = 1'b1;
				else begin
					cmd.tick      = 1'b1;
					cmd.dest_wait = 1'b1;
					cmd.elem_clr  = 1'b1;
					kind_d        = K_OK;
					mode_d        = M_UNLK;
				end
			end
			S_SEND: begin
				cmd.rd_sel = RD_ELEM;
				if (sts.out_free) begin
					cmd.push     = 1'b1;
					cmd.kind     = kind_q;
					cmd.last     = sts.elem_last && final_vec;
					cmd.elem_inc = 1'b1;
					if (sts.elem_last) begin
						cmd.dest_inc = (mode_q == M_BCAST);
						cmd.qi_inc   = (mode_q == M_UNLK);
					end
				end
			end
			S_RXEND: begin
				cmd.rx_clear = 1'b1;
				if (sts.peer_ok) begin
					cmd.tick = 1'b1;
					unique case (sts.opcode)
						OP_RX_LOCK: begin
							if (!sts.queue_dec) begin
								cmd.tick2     = 1'b1;
								cmd.dest_peer = 1'b1;
								cmd.elem_clr  = 1'b1;
								kind_d        = K_OK;
								mode_d        = M_ONE;
							end else if (!sts.q_full) cmd.q_append = 1'b1;
						end
						OP_RX_OK: begin
							if (sts.hit && !sts.grant_sat) begin
								cmd.grant_inc  = 1'b1;
								cmd.set_inside = sts.grant_enter;
							end
						end
						default: cmd.tick = 1'b1;
					endcase
				end
			end
			S_ERR: begin
				cmd.push = sts.out_free;
				cmd.kind = K_ERROR;
				cmd.last = 1'b1;
			end
			S_ENTER: begin
				cmd.push = sts.out_free;
				cmd.kind = K_ENTER;
				cmd.last = 1'b1;
			end
			default: cmd.rd_sel = RD_SELF;
		endcase
	end
endmodule

/* hw/rtl/vcdm_datapath.sv */
// Clock vector, lock table, wait queues and result register of the node.
module vcdm_datapath #(
	parameter int MAX_LOCKS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [3:0]      cfg_wdata,
	input  vcdm_pkg::item_t in_data,
	input  vcdm_pkg::cmd_t  cmd,
	output vcdm_pkg::sts_t  sts,
	output logic            out_valid,
	input  logic            out_ready,
	output vcdm_pkg::result_t out_data
);
	import vcdm_pkg::*;

	localparam int LSW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;

	logic [2:0]       self_q;
	logic [CNT_W-1:0] pcount_q;
	item_t            item_q;

	logic [CLK_W-1:0]  clk_q [N_PEERS];
	logic [CLK_W-1:0]  req_q [MAX_LOCKS][N_PEERS];
	logic [PEER_W-1:0] wq_q  [MAX_LOCKS][QCAP];
	logic [7:0]        slock_q [MAX_LOCKS];
	logic              valid_q [MAX_LOCKS];
	logic              inside_q [MAX_LOCKS];
	logic [2:0]        grant_q [MAX_LOCKS];
	logic [2:0]        wcnt_q [MAX_LOCKS];
	logic              earl_q, late_q;
	logic [CNT_W-1:0]  rxpos_q;
	logic [LSW-1:0]    cur_q;
	logic [2:0]        elem_q;
	logic [CNT_W-1:0]  dest_q;
	logic [2:0]        qi_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [CNT_W-1:0] n_w;
	logic [2:0]       s_w;
	logic             hit, full;
	logic [LSW-1:0]   hit_idx, free_idx;
	logic [2:0]       rd_addr;
	logic [CLK_W-1:0] rd_data, req_rd;
	logic             peer_ok, merge_en, out_free;
	logic [CNT_W-1:0] dest_p1, dest_p2;

	always_comb begin
		if (pcount_q < CNT_W'(2)) n_w = CNT_W'(2);
		else if (pcount_q > CNT_W'(N_PEERS)) n_w = CNT_W'(N_PEERS);
		else n_w = pcount_q;
		s_w = ({1'b0, self_q} >= n_w) ? 3'(n_w - CNT_W'(1)) : self_q;
	end

	// lowest matching and lowest free slot
	always_comb begin
		hit = 1'b0;
		full = 1'b1;
		hit_idx = '0;
		free_idx = '0;
		for (int l = MAX_LOCKS - 1; l >= 0; l--) begin
			if (valid_q[l] && slock_q[l] == item_q.lock_id) begin
				hit = 1'b1;
				hit_idx = LSW'(l);
			end
			if (!valid_q[l]) begin
				full = 1'b0;
				free_idx = LSW'(l);
			end
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_POS:  rd_addr = rxpos_q[2:0];
			RD_ELEM: rd_addr = elem_q;
			default: rd_addr = s_w;
		endcase
	end
	assign rd_data  = clk_q[rd_addr];
	assign req_rd   = req_q[hit_idx][rxpos_q[2:0]];
	assign peer_ok  = {1'b0, item_q.peer} < n_w;
	assign merge_en = cmd.rx_elem && peer_ok && (rxpos_q < n_w);
	assign out_free = !out_valid_q || out_ready;
	assign dest_p1  = dest_q + CNT_W'(1);
	assign dest_p2  = dest_q + CNT_W'(2);

	always_comb begin
		sts.opcode       = item_q.opcode;
		sts.element_last = item_q.element_last;
		sts.peer_ok      = peer_ok;
		sts.hit          = hit;
		sts.full         = full;
		sts.q_full       = wcnt_q[hit_idx] >= 3'(QCAP);
		sts.q_done       = qi_q == wcnt_q[cur_q];
		sts.wait_final   = ({1'b0, qi_q} + 4'd1) == {1'b0, wcnt_q[cur_q]};
		sts.dest_is_self = dest_q == {1'b0, s_w};
		sts.dest_done    = dest_q >= n_w;
		sts.dest_final   = (dest_p1 >= n_w) || (dest_p1 == {1'b0, s_w} && dest_p2 >= n_w);
		sts.elem_last    = {1'b0, elem_q} == (n_w - CNT_W'(1));
		sts.queue_dec    = hit && (inside_q[hit_idx] || (earl_q && !late_q)
			|| (!(late_q && !earl_q) && (s_w < item_q.peer)));
		sts.grant_sat    = grant_q[hit_idx] == 3'd7;
		sts.grant_enter  = ({1'b0, grant_q[hit_idx]} + 4'd1) == (n_w - CNT_W'(1));
		sts.out_free     = out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q      <= '0;
			pcount_q    <= CNT_W'(2);
			earl_q      <= 1'b0;
			late_q      <= 1'b0;
			rxpos_q     <= '0;
			out_valid_q <= 1'b0;
			for (int p = 0; p < N_PEERS; p++) clk_q[p] <= '0;
			for (int l = 0; l < MAX_LOCKS; l++) begin
				valid_q[l]  <= 1'b0;
				inside_q[l] <= 1'b0;
				grant_q[l]  <= '0;
				wcnt_q[l]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SELF_INDEX) self_q <= cfg_wdata[2:0];
				else pcount_q <= cfg_wdata;
			end
			if (cmd.tick)
				clk_q[s_w] <= rd_data + {{(CLK_W-2){1'b0}}, cmd.tick2, !cmd.tick2};
			else if (merge_en && item_q.clock_value > rd_data)
				clk_q[rxpos_q[2:0]] <= item_q.clock_value;
			if (cmd.rx_clear) begin
				earl_q  <= 1'b0;
				late_q  <= 1'b0;
				rxpos_q <= '0;
			end else if (cmd.rx_elem) begin
				if (merge_en && hit) begin
					if (req_rd < item_q.clock_value) earl_q <= 1'b1;
					if (req_rd > item_q.clock_value) late_q <= 1'b1;
				end
				if (peer_ok && rxpos_q < CNT_W'(N_PEERS)) rxpos_q <= rxpos_q + CNT_W'(1);
			end
			if (cmd.alloc) begin
				valid_q[free_idx]  <= 1'b1;
				inside_q[free_idx] <= 1'b0;
				grant_q[free_idx]  <= '0;
				wcnt_q[free_idx]   <= '0;
			end
			if (cmd.free_slot) begin
				valid_q[cur_q]  <= 1'b0;
				inside_q[cur_q] <= 1'b0;
				grant_q[cur_q]  <= '0;
				wcnt_q[cur_q]   <= '0;
			end
			if (cmd.q_append) wcnt_q[hit_idx] <= wcnt_q[hit_idx] + 3'd1;
			if (cmd.grant_inc) grant_q[hit_idx] <= grant_q[hit_idx] + 3'd1;
			if (cmd.set_inside) inside_q[hit_idx] <= 1'b1;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload and iteration registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= in_data;
		if (cmd.alloc) begin
			slock_q[free_idx] <= item_q.lock_id;
			cur_q <= free_idx;
		end
		if (cmd.set_cur_hit) cur_q <= hit_idx;
		if (cmd.copy_row)
			for (int p = 0; p < N_PEERS; p++) req_q[cur_q][p] <= clk_q[p];
		if (cmd.q_append) wq_q[hit_idx][wcnt_q[hit_idx]] <= item_q.peer;
		if (cmd.elem_clr) elem_q <= '0;
		else if (cmd.elem_inc) elem_q <= elem_q + 3'd1;
		if (cmd.dest_peer) dest_q <= {1'b0, item_q.peer};
		else if (cmd.dest_zero) dest_q <= '0;
		else if (cmd.dest_wait) dest_q <= {1'b0, wq_q[cur_q][qi_q]};
		else if (cmd.dest_inc) dest_q <= dest_p1;
		if (cmd.qi_clr) qi_q <= '0;
		else if (cmd.qi_inc) qi_q <= qi_q + 3'd1;
		if (cmd.push) begin
			out_q.kind <= cmd.kind;
			out_q.last <= cmd.last;
			case (cmd.kind)
				K_ENTER: begin
					out_q.dest_peer      <= '0;
					out_q.out_lock       <= item_q.lock_id;
					out_q.out_clock      <= '0;
					out_q.clock_position <= '0;
				end
				K_ERROR: begin
					out_q.dest_peer      <= item_q.peer;
					out_q.out_lock       <= item_q.lock_id;
					out_q.out_clock      <= '0;
					out_q.clock_position <= '0;
				end
				default: begin
					out_q.dest_peer      <= (cmd.kind == K_REPORT) ? '0 : dest_q[2:0];
					out_q.out_lock       <= (cmd.kind == K_MSG || cmd.kind == K_REPORT)
						? 8'd0 : item_q.lock_id;
					out_q.out_clock      <= rd_data;
					out_q.clock_position <= elem_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

/* hw/rtl/vector_clock_distributed_mutex.sv */
// Top level of the vector-clock distributed mutex node.
// Input items arrive on item_in, results leave on result_out, both valid/ready;
// a transaction happens when valid and ready are high at a rising edge.
// Configuration: cfg_we with cfg_index 0 (self index) or 1 (peer count) and
// cfg_wdata; write only while the node is idle.
// Each item is taken in the idle state and decoded in the next cycle, so an item
// that makes no result (tick, received element that is not last) then returns to idle.
// The last element of a received message is acted on in a further state after decode.
// Vectors leave through a single output register, one element per cycle while
// the receiver keeps up: n results for a send or report, (n-1) vectors of n for
// a lock request, and for an unlock one vector per queued peer, each fetched first.
// The sequencer holds one item at a time; input ready is low until the last
// result of the item has been loaded into the output register.
// A stalled receiver holds the output register and halts the sequencer.
// Reset clears the clock vector, the lock table and the reception state,
// sets self index 0 and peer count 2, and leaves the node idle.
module vector_clock_distributed_mutex #(
	parameter int MAX_LOCKS = 4
) (
	input logic          clk,
	input logic          arst_n,
	vcdm_item_if.sink    item_in,
	vcdm_result_if.source result_out,
	input logic          cfg_we,
	input logic          cfg_index,
	input logic [3:0]    cfg_wdata
);
	import vcdm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	vcdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vcdm_datapath #(.MAX_LOCKS(MAX_LOCKS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (item_in.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.out_data  (result_out.data)
	);

	assign item_in.ready = in_ready;
endmodule
